/* sv/rbm3_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the mean divider for the 3x3 RGB box mean block.
// No dependencies; imported by every module of the block.
package rbm3_pkg;

  // Default build limits, handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Field widths
  localparam int CFG_W = 11;
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int SUM_W = $clog2(9 * 255 + 1);

  // Register reset values and indexes
  localparam logic [CFG_W-1:0] WIDTH_RESET      = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET     = 11'd480;
  localparam logic [0:0]       REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0]       REG_IMAGE_HEIGHT = 1'b1;

  // Result queue depth (power of two)
  localparam int FIFO_DEPTH = 16;

  // Reciprocals for the floored means: x/6 = (x*2731)>>14, x/9 = (x*3641)>>15
  localparam int               RECIP_W     = 12;
  localparam logic [RECIP_W-1:0] RECIP_6   = 12'd2731;
  localparam logic [RECIP_W-1:0] RECIP_9   = 12'd3641;
  localparam int               SHIFT_6     = 14;
  localparam int               SHIFT_9     = 15;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXEL,
    OP_DRAIN
  } op_t;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } divisor_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
    logic            run_last;
  } result_t;

  // Floored mean of a window sum over 4, 6 or 9 pixels
  function automatic logic [CH_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                               input divisor_t dv);
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [CH_W-1:0]          q;
    prod = '0;
    case (dv)
      DIV_4: q = CH_W'(sum >> 2);
      DIV_6: begin
        prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_6);
        q    = CH_W'(prod >> SHIFT_6);
      end
      DIV_9: begin
        prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_9);
        q    = CH_W'(prod >> SHIFT_9);
      end
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

/* sv/rbm3_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, read data registered.
// Depends on rbm3_pkg for default sizes.
module rbm3_ram
  import rbm3_pkg::*;
#(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = DEF_MAX_WIDTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/rgb_box_mean_3x3_top.sv */
`timescale 1ns / 1ps
// Top level of the streaming 3x3 RGB box mean filter.
// Depends on rbm3_pkg and rbm3_ram (two line stores).
//
// Usage
//   Pixels enter in raster order on the in_* channel (kind = 0); each beat
//   with kind = 1 is a drain tick that releases one output of the last row.
//   Results leave on the out channel with frame_end on the final pixel of
//   the image and run_last on the last result of each input beat.
//   cfg_write sets image_width / image_height and restarts the frame; write
//   only while the block is idle.
// Pipeline and throughput
//   One input beat per clock while in_ready is high. Each beat passes the
//   line store read, window update, window sum and divide into the result
//   queue. Row-end pixels give two results, so the output side, one result
//   per clock while out_ready is high, sets the long-run rate there.
// Reset and stall
//   rst (synchronous) clears counters, pipeline valids and the result queue;
//   line stores are not cleared and are only read where written this frame.
//   When the receiver stalls, the 16-entry result queue absorbs results and
//   in_ready drops once it lacks room for the results still in flight.
module rgb_box_mean_3x3_top
  import rbm3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  // output channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CH_W-1:0]  filtered_red,
  output logic [CH_W-1:0]  filtered_green,
  output logic [CH_W-1:0]  filtered_blue,
  output logic             frame_end,
  output logic             run_last
);

  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCNT_W   = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int WX_W     = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
  localparam int HX_W     = (HCNT_W > CFG_W) ? HCNT_W : CFG_W;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int ROOM_W   = CNT_W + 1;
  localparam int COLSUM_W = $clog2(3 * 255 + 1);

  typedef struct packed {
    logic     has_main;
    logic     has_edge;
    logic     fe;
    logic [2:0] rowmask;   // bit 0: oldest row
    logic [2:0] colmask;   // bit 0: leftmost column
    divisor_t div_main;
    divisor_t div_edge;
  } item_ctl_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective image size
  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [WX_W-1:0]   w_wide;
  logic [HX_W-1:0]   h_wide;
  logic [WCNT_W-1:0] w_eff;
  logic [WCNT_W-1:0] w_m1;
  logic [HCNT_W-1:0] h_m1;

  always_comb begin
    w_wide = WX_W'(image_width);
    if (w_wide < WX_W'(2)) begin
      w_wide = WX_W'(2);
    end else if (w_wide > WX_W'(MAX_WIDTH)) begin
      w_wide = WX_W'(MAX_WIDTH);
    end
    h_wide = HX_W'(image_height);
    if (h_wide < HX_W'(2)) begin
      h_wide = HX_W'(2);
    end else if (h_wide > HX_W'(MAX_HEIGHT)) begin
      h_wide = HX_W'(MAX_HEIGHT);
    end
    w_eff = w_wide[WCNT_W-1:0];
    w_m1  = w_eff - WCNT_W'(1);
    h_m1  = h_wide[HCNT_W-1:0] - HCNT_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Frame position counters
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [WCNT_W-1:0] drain_count;

  logic              accept;
  op_t               op;
  logic [WCNT_W-1:0] c_wide;
  logic [HCNT_W-1:0] r_wide;
  logic [COL_W-1:0]  col_cur;
  logic [WCNT_W-1:0] d_col;
  logic [WCNT_W-1:0] d_next;
  logic              col_last;
  logic              row_last;
  logic [COL_W-1:0]  raddr_a;
  logic [COL_W-1:0]  raddr_b;
  item_ctl_t         ctl_in;

  assign accept = in_valid && in_ready;

  // Decode the beat against the current frame position
  always_comb begin
    op = OP_NONE;
    if (kind == 1'b0) begin
      if (drain_count == '0) op = OP_PIXEL;
    end else if (drain_count != '0) begin
      op = OP_DRAIN;
    end
    c_wide = WCNT_W'(col_count);
    if (c_wide >= w_eff) c_wide = w_m1;
    col_cur  = c_wide[COL_W-1:0];
    r_wide   = HCNT_W'(row_count);
    d_col    = w_eff - drain_count;
    d_next   = d_col + WCNT_W'(1);
    col_last = (c_wide == w_m1);
    row_last = (r_wide >= h_m1);
  end

  // Window shape and read addresses of the beat
  always_comb begin
    ctl_in  = '0;
    raddr_a = col_cur;
    raddr_b = col_cur;
    unique case (op)
      OP_PIXEL: begin
        ctl_in.has_main = (r_wide != '0) && (c_wide != '0);
        ctl_in.has_edge = (r_wide != '0) && col_last;
        ctl_in.rowmask  = {2'b11, r_wide >= HCNT_W'(2)};
        ctl_in.colmask  = {2'b11, c_wide >= WCNT_W'(2)};
      end
      OP_DRAIN: begin
        ctl_in.has_main = 1'b1;
        ctl_in.fe       = (drain_count == WCNT_W'(1));
        ctl_in.rowmask  = 3'b011;
        ctl_in.colmask  = {d_next < w_eff, 1'b1, d_col != '0};
        raddr_a         = d_col[COL_W-1:0];
        raddr_b         = d_next[COL_W-1:0];
      end
      default: ;
    endcase
    if ((&ctl_in.rowmask) && (&ctl_in.colmask)) begin
      ctl_in.div_main = DIV_9;
    end else if ((&ctl_in.rowmask) || (&ctl_in.colmask)) begin
      ctl_in.div_main = DIV_6;
    end else begin
      ctl_in.div_main = DIV_4;
    end
    ctl_in.div_edge = (&ctl_in.rowmask) ? DIV_6 : DIV_4;
  end

  // Config writes restart the frame; beats advance the counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
      drain_count  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      col_count   <= '0;
      row_count   <= '0;
      drain_count <= '0;
    end else if (accept) begin
      case (op)
        OP_PIXEL: begin
          if (col_last) begin
            col_count <= '0;
            if (row_last) begin
              row_count   <= '0;
              drain_count <= w_eff;
            end else begin
              row_count <= row_count + ROW_W'(1);
            end
          end else begin
            col_count <= col_cur + COL_W'(1);
          end
        end
        OP_DRAIN: drain_count <= drain_count - WCNT_W'(1);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read data, write-back and window update
  logic              s1_valid, s2_valid, s3_valid;
  op_t               s1_op;
  item_ctl_t         s1_ctl, s2_ctl, s3_ctl;
  logic [PIX_W-1:0]  s1_px;
  logic [COL_W-1:0]  s1_waddr;
  logic              s1_fwd_a, s1_fwd_b;
  logic [PIX_W-1:0]  fwd_older, fwd_newer;
  logic [PIX_W-1:0]  older_rd_a, older_rd_b, newer_rd_a, newer_rd_b;
  logic [PIX_W-1:0]  older_a, older_b, newer_a, newer_b;
  logic              wr_en;
  logic [PIX_W-1:0]  win [3][3];

  rbm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_line (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (s1_waddr),
    .wdata   (newer_a),
    .raddr_a (raddr_a),
    .rdata_a (older_rd_a),
    .raddr_b (raddr_b),
    .rdata_b (older_rd_b)
  );

  rbm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_line (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (s1_waddr),
    .wdata   (s1_px),
    .raddr_a (raddr_a),
    .rdata_a (newer_rd_a),
    .raddr_b (raddr_b),
    .rdata_b (newer_rd_b)
  );

  assign wr_en = s1_valid && (s1_op == OP_PIXEL);

  // Forward the word written in the same cycle as the read was issued
  always_comb begin
    older_a = s1_fwd_a ? fwd_older : older_rd_a;
    newer_a = s1_fwd_a ? fwd_newer : newer_rd_a;
    older_b = s1_fwd_b ? fwd_older : older_rd_b;
    newer_b = s1_fwd_b ? fwd_newer : newer_rd_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op     <= op;
    s1_ctl    <= ctl_in;
    s1_px     <= {in_red, in_green, in_blue};
    s1_waddr  <= col_cur;
    s1_fwd_a  <= wr_en && (s1_waddr == raddr_a);
    s1_fwd_b  <= wr_en && (s1_waddr == raddr_b);
    fwd_older <= newer_a;
    fwd_newer <= s1_px;
  end

  // Pixels shift the whole window; drains shift the two stored rows
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      case (s1_op)
        OP_PIXEL: begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= win[i][1];
            win[i][1] <= win[i][2];
          end
          win[0][2] <= older_a;
          win[1][2] <= newer_a;
          win[2][2] <= s1_px;
        end
        OP_DRAIN: begin
          win[0][0] <= win[0][1];
          win[1][0] <= win[1][1];
          win[0][1] <= older_a;
          win[1][1] <= newer_a;
          win[0][2] <= older_b;
          win[1][2] <= newer_b;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: masked window sums per channel
  logic [COLSUM_W-1:0] colsum   [3][3];   // [channel][column]
  logic [SUM_W-1:0]    main_sum [3];
  logic [SUM_W-1:0]    edge_sum [3];
  logic [SUM_W-1:0]    s3_main  [3];
  logic [SUM_W-1:0]    s3_edge  [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 3; j++) begin
        colsum[ch][j] = '0;
        for (int i = 0; i < 3; i++) begin
          if (s2_ctl.rowmask[i]) begin
            colsum[ch][j] = colsum[ch][j] +
                            COLSUM_W'(win[i][j][PIX_W-1-ch*CH_W -: CH_W]);
          end
        end
      end
      main_sum[ch] = (s2_ctl.colmask[0] ? SUM_W'(colsum[ch][0]) : '0) +
                     (s2_ctl.colmask[1] ? SUM_W'(colsum[ch][1]) : '0) +
                     (s2_ctl.colmask[2] ? SUM_W'(colsum[ch][2]) : '0);
      edge_sum[ch] = SUM_W'(colsum[ch][1]) + SUM_W'(colsum[ch][2]);
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl <= s1_ctl;
    s3_ctl <= s2_ctl;
    for (int ch = 0; ch < 3; ch++) begin
      s3_main[ch] <= main_sum[ch];
      s3_edge[ch] <= edge_sum[ch];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide and push into the result queue
  result_t          res_main, res_edge;
  logic             push_main, push_edge;
  logic [1:0]       push_n;

  always_comb begin
    res_main.red       = mean_div(s3_main[0], s3_ctl.div_main);
    res_main.green     = mean_div(s3_main[1], s3_ctl.div_main);
    res_main.blue      = mean_div(s3_main[2], s3_ctl.div_main);
    res_main.frame_end = s3_ctl.fe;
    res_main.run_last  = !s3_ctl.has_edge;
    res_edge.red       = mean_div(s3_edge[0], s3_ctl.div_edge);
    res_edge.green     = mean_div(s3_edge[1], s3_ctl.div_edge);
    res_edge.blue      = mean_div(s3_edge[2], s3_ctl.div_edge);
    res_edge.frame_end = 1'b0;
    res_edge.run_last  = 1'b1;
    push_main = s3_valid && s3_ctl.has_main;
    push_edge = s3_valid && s3_ctl.has_edge;
    push_n    = {1'b0, push_main} + {1'b0, push_edge};
  end

  // Result queue
  result_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fifo_count;
  logic             pop;
  result_t          head;

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_main) fifo_mem[wr_ptr] <= res_main;
    if (push_edge) fifo_mem[wr_ptr + PTR_W'(1)] <= res_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + PTR_W'(push_n);
      rd_ptr     <= rd_ptr + PTR_W'(pop);
      fifo_count <= fifo_count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  assign head           = fifo_mem[rd_ptr];
  assign out_valid      = (fifo_count != '0);
  assign filtered_red   = head.red;
  assign filtered_green = head.green;
  assign filtered_blue  = head.blue;
  assign frame_end      = head.frame_end;
  assign run_last       = head.run_last;

  // Room check: queue fill plus results still in the pipeline plus this beat
  logic [2:0] pending;

  always_comb begin
    pending = (s1_valid ? {2'b00, s1_ctl.has_main} + {2'b00, s1_ctl.has_edge} : 3'd0) +
              (s2_valid ? {2'b00, s2_ctl.has_main} + {2'b00, s2_ctl.has_edge} : 3'd0) +
              (s3_valid ? {2'b00, s3_ctl.has_main} + {2'b00, s3_ctl.has_edge} : 3'd0);
    in_ready = (ROOM_W'(fifo_count) + ROOM_W'(pending) + ROOM_W'(2)) <=
               ROOM_W'(FIFO_DEPTH);
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (ROOM_W'(fifo_count) + ROOM_W'(push_n)) <= ROOM_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_drain_pos: assert property (@(posedge clk) disable iff (rst)
    (drain_count != '0) |-> (col_count == '0) && (row_count == '0))
    else $error("drain pending with frame position not at origin");

  a_edge_pair: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ctl.has_edge) |-> s3_ctl.has_main)
    else $error("row-end result without its main result");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("frame_end on a result that is not last of its beat");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for rgb_box_mean_3x3_top: directed table, then random frames.
// Depends on rbm3_pkg and the RTL of the filter; carries its own window-mean predictor.
module tb_top;
  import rbm3_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam int   MAX_W = DEF_MAX_WIDTH;
  localparam int   MAX_H = DEF_MAX_HEIGHT;
  localparam int   PREDICTED = -1;
  localparam int   ITEM_BUDGET = 1850;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   TAIL_CYCLES = 12;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   N_DIR = 26;
  localparam int   WIDE_EXTRA = 40;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct {
    bit              is_cfg;
    logic [0:0]      reg_idx;
    logic [CFG_W-1:0] reg_val;
    logic            kind_v;
    logic [CH_W-1:0] red_v;
    logic [CH_W-1:0] grn_v;
    logic [CH_W-1:0] blu_v;
    int              n_typed;
    logic [CH_W-1:0] typed_mean;
    bit              typed_fe;
  } stim_row_t;

  // Directed table: typed results where obvious, predictor elsewhere
  stim_row_t dir_tab [N_DIR] = '{
    // reset defaults: 640 wide, so the first pixel and a stray drain give nothing
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'h12, 8'h34, 8'h56, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    // smallest image, all white
    '{1, REG_IMAGE_WIDTH, 11'd2, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    '{1, REG_IMAGE_HEIGHT, 11'd2, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 2, 8'd255, 0},
    // pixel while the last row is pending is dropped
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'h00, 8'h00, 8'h00, 1, 8'd255, 0},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'h00, 8'h00, 8'h00, 1, 8'd255, 1},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    // 3x3 image: corner, edge and full windows
    '{1, REG_IMAGE_WIDTH, 11'd3, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    '{1, REG_IMAGE_HEIGHT, 11'd3, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 0, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd255, 8'd0, 8'd255, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd0, 8'd255, 8'd0, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd255, 8'd255, 8'd255, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd1, 8'd254, 8'd128, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd0, 8'd0, 8'd0, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd254, 8'd1, 8'd127, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd255, 8'd255, 8'd0, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd0, 8'd0, 8'd255, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_PIXEL, 8'd128, 8'd64, 8'd32, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'd0, 8'd0, 8'd0, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'd0, 8'd0, 8'd0, PREDICTED, 8'd0, 0},
    '{0, 1'b0, 11'd0, KIND_DRAIN, 8'd0, 8'd0, 8'd0, PREDICTED, 8'd0, 0}
  };

  // DUT signals
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             kind = KIND_PIXEL;
  logic [CH_W-1:0]  in_red = '0;
  logic [CH_W-1:0]  in_green = '0;
  logic [CH_W-1:0]  in_blue = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CH_W-1:0]  filtered_red;
  logic [CH_W-1:0]  filtered_green;
  logic [CH_W-1:0]  filtered_blue;
  logic             frame_end;
  logic             run_last;

  // Predictor state
  logic [PIX_W-1:0] older_row [MAX_W];
  logic [PIX_W-1:0] newer_row [MAX_W];
  win_t             win;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      drain_left;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  result_t mean_q [$];   // expected results, oldest first
  result_t fresh_q [$];  // results of the beat just predicted

  bit no_idle = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int beats_in = 0;
  int results_chk = 0;
  int frames_done = 0;

  rgb_box_mean_3x3_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_red   (filtered_red),
    .filtered_green (filtered_green),
    .filtered_blue  (filtered_blue),
    .frame_end      (frame_end),
    .run_last       (run_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_w();
    int unsigned w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = height_reg;
    if (h < 2) h = 2;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // Floored per-channel mean over g[rlo..rhi][clo..chi]
  function automatic result_t box_mean(win_t g, int rlo, int rhi, int clo, int chi,
                                       bit fe);
    int unsigned sr, sg, sb, cnt;
    result_t     res;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int i = rlo; i <= rhi; i++) begin
      for (int j = clo; j <= chi; j++) begin
        sr += g[i][j][23:16];
        sg += g[i][j][15:8];
        sb += g[i][j][7:0];
      end
    end
    cnt = (rhi - rlo + 1) * (chi - clo + 1);
    res.red       = CH_W'(sr / cnt);
    res.green     = CH_W'(sg / cnt);
    res.blue      = CH_W'(sb / cnt);
    res.frame_end = fe;
    res.run_last  = 1'b0;
    return res;
  endfunction

  // Advance the predictor by one accepted beat; results land in fresh_q
  task automatic predict_beat(input logic k, input logic [CH_W-1:0] rv,
                              input logic [CH_W-1:0] gv, input logic [CH_W-1:0] bv);
    int unsigned w, h, c, d;
    int          rlo, clo, chi;
    win_t        g;
    result_t     res_a, res_b;
    bit          have_a, have_b;
    fresh_q.delete();
    w = eff_w();
    h = eff_h();
    if (k == KIND_DRAIN) begin
      if (drain_left == 0 || drain_left > w) return;
      // bottom row: window made of the row above and its own row
      d = w - drain_left;
      g = '0;
      g[0][1] = older_row[d];
      g[1][1] = newer_row[d];
      clo = 1;
      chi = 1;
      if (d > 0) begin
        g[0][0] = older_row[d-1];
        g[1][0] = newer_row[d-1];
        clo = 0;
      end
      if (d + 1 < w) begin
        g[0][2] = older_row[d+1];
        g[1][2] = newer_row[d+1];
        chi = 2;
      end
      drain_left--;
      res_a = box_mean(g, 0, 1, clo, chi, drain_left == 0);
      res_a.run_last = 1'b1;
      fresh_q.push_back(res_a);
    end else begin
      if (drain_left != 0) return;
      c = col_pos;
      if (c >= w) c = w - 1;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = older_row[c];
      win[1][2] = newer_row[c];
      win[2][2] = {rv, gv, bv};
      older_row[c] = newer_row[c];
      newer_row[c] = {rv, gv, bv};
      have_a = 1'b0;
      have_b = 1'b0;
      if (row_pos >= 1) begin
        rlo = (row_pos >= 2) ? 0 : 1;
        if (c >= 1) begin
          res_a  = box_mean(win, rlo, 2, (c >= 2) ? 0 : 1, 2, 1'b0);
          have_a = 1'b1;
        end
        // row end: the last column of the row above as well
        if (c == w - 1) begin
          res_b  = box_mean(win, rlo, 2, 1, 2, 1'b0);
          have_b = 1'b1;
        end
      end
      if (have_b) res_b.run_last = 1'b1;
      else if (have_a) res_a.run_last = 1'b1;
      if (have_a) fresh_q.push_back(res_a);
      if (have_b) fresh_q.push_back(res_b);
      if (c >= w - 1) begin
        col_pos = 0;
        if (row_pos >= h - 1) begin
          row_pos    = 0;
          drain_left = w;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int n;
    if (no_idle) return 0;
    n = $urandom_range(0, 99);
    if (n < 70) return 0;
    if (n < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    int n;
    n = $urandom_range(0, 7);
    if (n == 0) return '0;
    if (n == 1) return '1;
    return CH_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    int n;
    n = $urandom_range(0, 19);
    if (n == 0) return CFG_W'($urandom_range(0, 1));
    if (n < 3) return CFG_W'($urandom_range(11, 40));
    return CFG_W'($urandom_range(2, 10));
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    int n;
    n = $urandom_range(0, 19);
    if (n == 0) return CFG_W'($urandom_range(0, 1));
    if (n < 3) return CFG_W'($urandom_range(6, 12));
    return CFG_W'($urandom_range(2, 5));
  endfunction

  // One input beat; expectations from the predictor or typed in
  task automatic send_beat(input logic k, input logic [CH_W-1:0] rv,
                           input logic [CH_W-1:0] gv, input logic [CH_W-1:0] bv,
                           input int n_typed, input logic [CH_W-1:0] tmean, input bit tfe);
    int      gap;
    result_t res;
    in_valid <= 1'b1;
    kind     <= k;
    in_red   <= rv;
    in_green <= gv;
    in_blue  <= bv;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    predict_beat(k, rv, gv, bv);
    if (n_typed < 0) begin
      foreach (fresh_q[i]) mean_q.push_back(fresh_q[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        res.red       = tmean;
        res.green     = tmean;
        res.blue      = tmean;
        res.frame_end = (i == n_typed - 1) ? tfe : 1'b0;
        res.run_last  = (i == n_typed - 1);
        mean_q.push_back(res);
      end
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write once the block has gone quiet; restarts the frame
  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    col_pos    = 0;
    row_pos    = 0;
    drain_left = 0;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Output side: check each result beat, then choose ready for the next edge
  always @(posedge clk) begin : out_side
    int      gap;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        $error("result with none expected: red %0d green %0d blue %0d",
               filtered_red, filtered_green, filtered_blue);
        fail_count++;
      end else begin
        want = mean_q.pop_front();
        results_chk++;
        if (filtered_red !== want.red) begin
          $error("filtered_red: expected %0d, got %0d", want.red, filtered_red);
          fail_count++;
        end
        if (filtered_green !== want.green) begin
          $error("filtered_green: expected %0d, got %0d", want.green, filtered_green);
          fail_count++;
        end
        if (filtered_blue !== want.blue) begin
          $error("filtered_blue: expected %0d, got %0d", want.blue, filtered_blue);
          fail_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
          fail_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, run_last);
          fail_count++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      gap = pick_gap();
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= gap - 1;
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb_box_mean_3x3_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    int          small_items;
    int          phase;
    int          frames;
    int          cut;
    int          sent;
    int unsigned w, h;
    bit          restart;
    // predictor reset
    for (int i = 0; i < MAX_W; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    win        = '0;
    col_pos    = 0;
    row_pos    = 0;
    drain_left = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    small_items = 0;
    phase       = 0;
    restart     = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      else
        send_beat(dir_tab[i].kind_v, dir_tab[i].red_v, dir_tab[i].grn_v, dir_tab[i].blu_v,
                  dir_tab[i].n_typed, dir_tab[i].typed_mean, dir_tab[i].typed_fe);
    end
    frames_done += 2;

    // random frames
    while (small_items < ITEM_BUDGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase == 2) begin
        // widest image, clamped from the top of the register range
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
        w = eff_w();
        // first row and the start of the second only; the next write drops the rest
        for (int i = 0; i < w + WIDE_EXTRA; i++)
          send_beat(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan(), PREDICTED, '0, 0);
        small_items += w + WIDE_EXTRA;
        restart = 1'b1;
      end else begin
        if (restart || $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 3) == 0)
            write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 2047)));
          write_reg(REG_IMAGE_WIDTH, pick_width());
        end
        if (restart || $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 3) == 0)
            write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 2047)));
          write_reg(REG_IMAGE_HEIGHT, pick_height());
        end
        restart = 1'b0;
        w = eff_w();
        h = eff_h();
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
          // now and then the last frame is cut short by a register write
          if (f == frames - 1 && $urandom_range(0, 5) == 0)
            cut = $urandom_range(1, w * h + w - 1);
          else
            cut = w * h + w;
          sent = 0;
          for (int i = 0; i < w * h && sent < cut; i++) begin
            if ($urandom_range(0, 19) == 0)
              send_beat(KIND_DRAIN, rand_chan(), rand_chan(), rand_chan(), PREDICTED, '0, 0);
            send_beat(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan(), PREDICTED, '0, 0);
            sent++;
          end
          for (int i = 0; i < w && sent < cut; i++) begin
            if ($urandom_range(0, 19) == 0)
              send_beat(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan(), PREDICTED, '0, 0);
            send_beat(KIND_DRAIN, rand_chan(), rand_chan(), rand_chan(), PREDICTED, '0, 0);
            sent++;
          end
          small_items += sent;
          if (sent < w * h + w) restart = 1'b1;
          else frames_done++;
        end
      end
      phase++;
    end

    // wind down
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats and %0d checked results", beats_in, results_chk);
    $display("over %0d complete frames in %0d random phases, widths 2 to 1024", frames_done,
             phase);
    if (fail_count == 0)
      $display("rgb_box_mean_3x3_top test passed");
    else
      $display("rgb_box_mean_3x3_top test failed");
    $finish;
  end

endmodule

/* sim.f */
sv/rbm3_pkg.sv
sv/rbm3_ram.sv
sv/rgb_box_mean_3x3_top.sv
bench/tb_top.sv
